### hdl/quintic_waypoint_trajectory_3axis_core_defines.svh
// Assertion macros shared by the checker of the quintic waypoint trajectory core.
// Depends on nothing; taken in by the checker file with an include.
`ifndef QUINTIC_WAYPOINT_TRAJECTORY_3AXIS_CORE_DEFINES_SVH
`define QUINTIC_WAYPOINT_TRAJECTORY_3AXIS_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QWT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QWT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/qwt_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and defaults for the quintic waypoint trajectory core.
// Depends on nothing; the core, store, divider and checker refer to it by scoped names.
package qwt_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COUNT_OUT_W    = 7;
    localparam int DIV_STEPS      = 64;

    // Beat kinds on the input channel.
    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_EVAL   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_NONINC = 2'd2;
    localparam logic [1:0] STAT_SAT    = 2'd3;

    typedef struct packed {
        logic        [1:0]  kind;
        logic        [31:0] when;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic        [1:0]  status;
        logic        [6:0]  point_count;
    } out_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } pos_t;

endpackage

### hdl/quintic_waypoint_trajectory_3axis_core.sv
`timescale 1ns / 1ps
// Quintic waypoint trajectory core for three axes. One beat is taken at a time and gives one
// result beat. Appends, clears and evaluations of an empty store go straight to the result,
// while a single-point evaluation first reads the store. A full evaluation steps over segments
// in a linear search of the time memory, fetches the four neighbouring waypoints, then makes
// between four and ten passes of the shared radix-2 divider (one for the normalised time, up
// to three slopes per axis) and, per axis, seven passes of the shared scaling multiplier and
// a coefficient step. No clearing pass after reset.
// Depends on qwt_pkg, qwt_store, qwt_div and qwt_muls.
module quintic_waypoint_trajectory_3axis_core #(
    parameter int MAX_POINTS = qwt_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = qwt_pkg::FRAC_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  qwt_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output qwt_pkg::out_t m_data
);

    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int EXT_W   = CNT_W + 1;
    localparam int SHIFT_V = 32 - FRAC_BITS;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_ONE_WT   = 4'd1;
    localparam logic [3:0] ST_SRCH_RD  = 4'd2;
    localparam logic [3:0] ST_SRCH_CHK = 4'd3;
    localparam logic [3:0] ST_LOAD     = 4'd4;
    localparam logic [3:0] ST_DIV_S    = 4'd5;
    localparam logic [3:0] ST_SLOPE    = 4'd6;
    localparam logic [3:0] ST_MUL_A    = 4'd7;
    localparam logic [3:0] ST_MUL_B    = 4'd8;
    localparam logic [3:0] ST_COEF     = 4'd9;
    localparam logic [3:0] ST_HORN     = 4'd10;
    localparam logic [3:0] ST_DONE     = 4'd11;

    // Velocity at an interior point from the slopes on either side.
    function automatic logic signed [31:0] vel_comb(input logic signed [63:0] sa,
                                                    input logic signed [63:0] sb);
        logic               pa;
        logic               pb;
        logic signed [64:0] sum;
        logic signed [64:0] half;
        begin
            pa   = !sa[63] && (sa != 64'sd0);
            pb   = !sb[63] && (sb != 64'sd0);
            sum  = 65'(sa) + 65'(sb);
            half = sum[64] ? -((-sum) >>> 1) : (sum >>> 1);
            if (pa != pb) begin
                vel_comb = 32'sd0;
            end else if (half > 65'sd2147483647) begin
                vel_comb = 32'sh7fffffff;
            end else if (half < -65'sd2147483648) begin
                vel_comb = 32'sh80000000;
            end else begin
                vel_comb = half[31:0];
            end
        end
    endfunction

    function automatic logic signed [31:0] pos_axis(input qwt_pkg::pos_t p,
                                                    input logic [1:0] ax);
        begin
            case (ax)
                2'd0:    pos_axis = p.x;
                2'd1:    pos_axis = p.y;
                default: pos_axis = p.z;
            endcase
        end
    endfunction

    logic [3:0]          state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [31:0]         last_time_reg;
    logic [31:0]         first_time_reg;
    logic [31:0]         tc_reg;
    logic [IDX_W-1:0]    i_reg;
    logic [2:0]          j_reg;
    logic [1:0]          sl_reg;
    logic [1:0]          ax_reg;
    logic [2:0]          hs_reg;
    logic                launched_reg;
    logic                sat_reg;
    logic [31:0]         lt_reg [4];
    qwt_pkg::pos_t       lp_reg [4];
    logic [32:0]         s_reg;
    logic signed [63:0]  slope_reg [3];
    logic signed [63:0]  a_reg;
    logic signed [63:0]  b_reg;
    logic signed [63:0]  k3_reg;
    logic signed [63:0]  k4_reg;
    logic signed [63:0]  h_reg;
    logic signed [31:0]  res_reg [3];
    logic [1:0]          stat_reg;
    logic                m_valid_reg;
    qwt_pkg::out_t       m_data_reg;

    logic                accept;
    logic                is_full;
    logic                non_inc;
    logic                append_ok;
    logic [31:0]         clamp_t;
    logic [EXT_W-1:0]    n_ext;
    logic [EXT_W-1:0]    i_ext;
    logic                has_next;
    logic                first_seg;
    logic [EXT_W-1:0]    ld_sum;
    logic [IDX_W-1:0]    ld_addr;
    logic [IDX_W-1:0]    rd_addr;
    logic [31:0]         rd_time;
    qwt_pkg::pos_t       rd_pos;
    qwt_pkg::pos_t       wr_pos;
    logic [1:0]          sl_nx;
    logic signed [31:0]  sl_p0;
    logic signed [31:0]  sl_p1;
    logic [31:0]         dt;
    logic signed [32:0]  dp;
    logic [32:0]         dp_mag;
    logic                slope_skip;
    logic [31:0]         dur;
    logic [31:0]         diff;
    logic signed [31:0]  v0;
    logic signed [31:0]  v1;
    logic signed [31:0]  p0_ax;
    logic signed [31:0]  p1_ax;
    logic signed [63:0]  d;
    logic                div_start;
    logic                div_done;
    logic [63:0]         div_dvd;
    logic [31:0]         div_dsr;
    logic [63:0]         div_q;
    logic                mul_start;
    logic                mul_done;
    logic signed [63:0]  mul_x;
    logic [32:0]         mul_s;
    logic signed [63:0]  mres;
    logic signed [63:0]  horn_sum;
    logic                fin_sat;
    logic signed [31:0]  fin_val;

    // Input handshake and append checks.
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign is_full   = (count_reg == CNT_W'(MAX_POINTS));
    assign non_inc   = (count_reg != '0) && (s_data.when <= last_time_reg);
    assign append_ok = accept && (s_data.kind == qwt_pkg::KIND_APPEND) && !is_full && !non_inc;
    assign wr_pos    = '{x: s_data.pos_x, y: s_data.pos_y, z: s_data.pos_z};

    // Query time clamped to the stored span.
    always_comb begin
        clamp_t = s_data.when;
        if (s_data.when < first_time_reg) begin
            clamp_t = first_time_reg;
        end
        if (s_data.when > last_time_reg) begin
            clamp_t = last_time_reg;
        end
    end

    assign n_ext     = EXT_W'(count_reg);
    assign i_ext     = EXT_W'(i_reg);
    assign has_next  = (i_ext + EXT_W'(2)) < n_ext;
    assign first_seg = (i_reg == '0);

    // Fetch address for the four neighbours of segment i; missing ones read entry zero.
    assign ld_sum = i_ext + EXT_W'(j_reg);
    always_comb begin
        if ((ld_sum == '0) || ((ld_sum - EXT_W'(1)) >= n_ext)) begin
            ld_addr = '0;
        end else begin
            ld_addr = IDX_W'(ld_sum - EXT_W'(1));
        end
    end

    always_comb begin
        case (state_reg)
            ST_SRCH_RD: rd_addr = IDX_W'(i_reg + 1'b1);
            ST_LOAD:    rd_addr = ld_addr;
            default:    rd_addr = '0;
        endcase
    end

    qwt_store #(
        .MAX_POINTS (MAX_POINTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (append_ok),
        .wr_addr (IDX_W'(count_reg)),
        .wr_time (s_data.when),
        .wr_pos  (wr_pos),
        .rd_addr (rd_addr),
        .rd_time (rd_time),
        .rd_pos  (rd_pos)
    );

    // Slope between neighbour sl and sl+1 on the current axis.
    assign sl_nx      = sl_reg + 2'd1;
    assign sl_p0      = pos_axis(lp_reg[sl_reg], ax_reg);
    assign sl_p1      = pos_axis(lp_reg[sl_nx], ax_reg);
    assign dt         = lt_reg[sl_nx] - lt_reg[sl_reg];
    assign dp         = 33'(sl_p1) - 33'(sl_p0);
    assign dp_mag     = dp[32] ? 33'(-dp) : 33'(dp);
    assign slope_skip = ((sl_reg == 2'd0) && first_seg) || ((sl_reg == 2'd2) && !has_next)
                        || (dt == '0);

    assign dur  = lt_reg[2] - lt_reg[1];
    assign diff = tc_reg - lt_reg[1];

    assign v0 = first_seg ? 32'sd0 : vel_comb(slope_reg[0], slope_reg[1]);
    assign v1 = has_next ? vel_comb(slope_reg[1], slope_reg[2]) : 32'sd0;

    assign p0_ax = pos_axis(lp_reg[1], ax_reg);
    assign p1_ax = pos_axis(lp_reg[2], ax_reg);
    assign d     = 64'(p1_ax) - 64'(p0_ax);

    // Shared divider: normalised time first, then slopes.
    assign div_start = ((state_reg == ST_DIV_S) || ((state_reg == ST_SLOPE) && !slope_skip))
                       && !launched_reg;
    assign div_dvd   = (state_reg == ST_DIV_S) ? {diff, 32'h0} : (64'(dp_mag) << FRAC_BITS);
    assign div_dsr   = (state_reg == ST_DIV_S) ? dur : dt;

    qwt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    // Shared scaling multiplier: velocity times duration, then the Horner steps.
    assign mul_start = ((state_reg == ST_MUL_A) || (state_reg == ST_MUL_B)
                        || (state_reg == ST_HORN)) && !launched_reg;
    always_comb begin
        case (state_reg)
            ST_MUL_A: mul_x = 64'(v0) <<< SHIFT_V;
            ST_MUL_B: mul_x = 64'(v1) <<< SHIFT_V;
            default:  mul_x = (hs_reg == 3'd4) ? (a_reg + h_reg) : h_reg;
        endcase
    end
    assign mul_s = ((state_reg == ST_MUL_A) || (state_reg == ST_MUL_B)) ? {1'b0, dur} : s_reg;

    qwt_muls u_muls (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .x       (mul_x),
        .s       (mul_s),
        .done    (mul_done),
        .result  (mres)
    );

    always_comb begin
        case (hs_reg)
            3'd0:    horn_sum = k4_reg + mres;
            3'd1:    horn_sum = k3_reg + mres;
            3'd4:    horn_sum = mres + 64'(p0_ax);
            default: horn_sum = mres;
        endcase
    end

    // Final saturation to the signed 32-bit position range.
    always_comb begin
        fin_sat = 1'b1;
        if (horn_sum > 64'sd2147483647) begin
            fin_val = 32'sh7fffffff;
        end else if (horn_sum < -64'sd2147483648) begin
            fin_val = 32'sh80000000;
        end else begin
            fin_val = horn_sum[31:0];
            fin_sat = 1'b0;
        end
    end

    // Sequencer for one beat at a time.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            launched_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // The result register is refilled in the done state, so it is only emptied elsewhere.
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            if (div_done || mul_done) begin
                launched_reg <= 1'b0;
            end else if (div_start || mul_start) begin
                launched_reg <= 1'b1;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        res_reg[0] <= 32'sd0;
                        res_reg[1] <= 32'sd0;
                        res_reg[2] <= 32'sd0;
                        stat_reg   <= qwt_pkg::STAT_OK;
                        sat_reg    <= 1'b0;
                        i_reg      <= '0;
                        tc_reg     <= clamp_t;
                        state_reg  <= ST_DONE;
                        case (s_data.kind)
                            qwt_pkg::KIND_APPEND: begin
                                if (is_full) begin
                                    stat_reg <= qwt_pkg::STAT_FULL;
                                end else if (non_inc) begin
                                    stat_reg <= qwt_pkg::STAT_NONINC;
                                end else begin
                                    count_reg     <= count_reg + 1'b1;
                                    last_time_reg <= s_data.when;
                                    if (count_reg == '0) begin
                                        first_time_reg <= s_data.when;
                                    end
                                end
                            end
                            qwt_pkg::KIND_CLEAR: begin
                                count_reg <= '0;
                            end
                            qwt_pkg::KIND_EVAL: begin
                                if (count_reg == CNT_W'(1)) begin
                                    state_reg <= ST_ONE_WT;
                                end else if (count_reg != '0) begin
                                    state_reg <= ST_SRCH_RD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_ONE_WT: begin
                    res_reg[0] <= rd_pos.x;
                    res_reg[1] <= rd_pos.y;
                    res_reg[2] <= rd_pos.z;
                    state_reg  <= ST_DONE;
                end
                ST_SRCH_RD: begin
                    j_reg     <= 3'd0;
                    state_reg <= has_next ? ST_SRCH_CHK : ST_LOAD;
                end
                ST_SRCH_CHK: begin
                    if (tc_reg > rd_time) begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_SRCH_RD;
                    end else begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (j_reg != 3'd0) begin
                        lt_reg[2'(j_reg - 3'd1)] <= rd_time;
                        lp_reg[2'(j_reg - 3'd1)] <= rd_pos;
                    end
                    if (j_reg == 3'd4) begin
                        state_reg <= ST_DIV_S;
                    end else begin
                        j_reg <= j_reg + 3'd1;
                    end
                end
                ST_DIV_S: begin
                    if (div_done) begin
                        if (dur == '0) begin
                            s_reg <= '0;
                        end else if (div_q > 64'h1_0000_0000) begin
                            s_reg <= 33'h1_0000_0000;
                        end else begin
                            s_reg <= div_q[32:0];
                        end
                        ax_reg    <= 2'd0;
                        sl_reg    <= 2'd0;
                        state_reg <= ST_SLOPE;
                    end
                end
                ST_SLOPE: begin
                    if (slope_skip || div_done) begin
                        if (slope_skip) begin
                            slope_reg[sl_reg] <= 64'sd0;
                        end else begin
                            slope_reg[sl_reg] <= dp[32] ? -$signed(div_q) : $signed(div_q);
                        end
                        if (sl_reg == 2'd2) begin
                            state_reg <= ST_MUL_A;
                        end else begin
                            sl_reg <= sl_nx;
                        end
                    end
                end
                ST_MUL_A: begin
                    if (mul_done) begin
                        a_reg     <= mres;
                        state_reg <= ST_MUL_B;
                    end
                end
                ST_MUL_B: begin
                    if (mul_done) begin
                        b_reg     <= mres;
                        state_reg <= ST_COEF;
                    end
                end
                ST_COEF: begin
                    k3_reg    <= 64'sd10 * d - 64'sd6 * a_reg - 64'sd4 * b_reg;
                    k4_reg    <= 64'sd8 * a_reg + 64'sd7 * b_reg - 64'sd15 * d;
                    h_reg     <= 64'sd6 * d - 64'sd3 * a_reg - 64'sd3 * b_reg;
                    hs_reg    <= 3'd0;
                    state_reg <= ST_HORN;
                end
                ST_HORN: begin
                    if (mul_done) begin
                        if (hs_reg == 3'd4) begin
                            res_reg[ax_reg] <= fin_val;
                            sat_reg         <= sat_reg || fin_sat;
                            if (ax_reg == 2'd2) begin
                                stat_reg  <= (sat_reg || fin_sat) ? qwt_pkg::STAT_SAT
                                                                  : qwt_pkg::STAT_OK;
                                state_reg <= ST_DONE;
                            end else begin
                                ax_reg    <= ax_reg + 2'd1;
                                sl_reg    <= 2'd0;
                                state_reg <= ST_SLOPE;
                            end
                        end else begin
                            h_reg  <= horn_sum;
                            hs_reg <= hs_reg + 3'd1;
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.out_x       <= res_reg[0];
                        m_data_reg.out_y       <= res_reg[1];
                        m_data_reg.out_z       <= res_reg[2];
                        m_data_reg.status      <= stat_reg;
                        m_data_reg.point_count <= qwt_pkg::COUNT_OUT_W'(count_reg);
                        m_valid_reg            <= 1'b1;
                        state_reg              <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hdl/qwt_store.sv
`timescale 1ns / 1ps
// Waypoint store: one memory of times and one of positions, one write and one read port.
// Depends on qwt_pkg for the position type.
module qwt_store #(
    parameter int MAX_POINTS = qwt_pkg::MAX_POINTS_DEF
) (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [$clog2(MAX_POINTS)-1:0]   wr_addr,
    input  logic [31:0]                     wr_time,
    input  qwt_pkg::pos_t                   wr_pos,
    input  logic [$clog2(MAX_POINTS)-1:0]   rd_addr,
    output logic [31:0]                     rd_time,
    output qwt_pkg::pos_t                   rd_pos
);

    logic [31:0]   time_mem [MAX_POINTS];
    qwt_pkg::pos_t pos_mem  [MAX_POINTS];

    // Write port, used by appends only.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            time_mem[wr_addr] <= wr_time;
            pos_mem[wr_addr]  <= wr_pos;
        end
    end

    // Registered read port; data appears in the cycle after the address.
    always_ff @(posedge aclk) begin
        rd_time <= time_mem[rd_addr];
        rd_pos  <= pos_mem[rd_addr];
    end

endmodule

### hdl/qwt_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Depends on qwt_pkg for the step count.
module qwt_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    localparam int CNT_W = $clog2(qwt_pkg::DIV_STEPS);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      rem_reg;
    logic [31:0]      dsr_reg;
    logic [63:0]      quo_reg;
    logic [32:0]      rem_sh;
    logic             ge;

    // Shift the next dividend bit in and try the subtraction.
    assign rem_sh = {rem_reg, quo_reg[63]};
    assign ge     = rem_sh >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
                quo_reg  <= dividend;
            end else if (busy_reg) begin
                rem_reg <= ge ? 32'(rem_sh - {1'b0, dsr_reg}) : rem_sh[31:0];
                quo_reg <= {quo_reg[62:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(qwt_pkg::DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hdl/qwt_muls.sv
`timescale 1ns / 1ps
// Scaling multiplier: trunc(x * s / 2^32) for signed 64-bit x and unsigned 33-bit s.
// One 32x33 multiplier used twice; depends on nothing else.
module qwt_muls (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] x,
    input  logic        [32:0] s,
    output logic               done,
    output logic signed [63:0] result
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HI   = 2'd1;
    localparam logic [1:0] PH_LO   = 2'd2;
    localparam logic [1:0] PH_SUM  = 2'd3;

    logic [1:0]         phase_reg;
    logic               done_reg;
    logic [63:0]        mag_reg;
    logic               neg_reg;
    logic [32:0]        s_reg;
    logic [63:0]        hi_reg;
    logic [32:0]        lo_reg;
    logic signed [63:0] res_reg;
    logic [31:0]        mul_a;
    logic [64:0]        prod;
    logic [63:0]        sum;

    // Upper half of the magnitude first, then the lower half.
    assign mul_a = (phase_reg == PH_HI) ? mag_reg[63:32] : mag_reg[31:0];
    assign prod  = 65'(mul_a) * 65'(s_reg);
    assign sum   = hi_reg + 64'(lo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (phase_reg)
                PH_IDLE: begin
                    if (start) begin
                        mag_reg   <= x[63] ? 64'(-x) : 64'(x);
                        neg_reg   <= x[63];
                        s_reg     <= s;
                        phase_reg <= PH_HI;
                    end
                end
                PH_HI: begin
                    hi_reg    <= prod[63:0];
                    phase_reg <= PH_LO;
                end
                PH_LO: begin
                    lo_reg    <= prod[64:32];
                    phase_reg <= PH_SUM;
                end
                PH_SUM: begin
                    res_reg   <= neg_reg ? -$signed(sum) : $signed(sum);
                    done_reg  <= 1'b1;
                    phase_reg <= PH_IDLE;
                end
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

### hdl/qwt_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the quintic waypoint trajectory core, bound to the top level.
// Depends on qwt_pkg and the assertion macro header.
`include "quintic_waypoint_trajectory_3axis_core_defines.svh"

module qwt_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input qwt_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input qwt_pkg::out_t m_data
);

    logic out_stall;
    logic in_beat;
    logic drop_beat;
    logic zero_pos;
    logic sat_beat;
    logic at_limit;

    // Conditions watched by the assertions below.
    assign out_stall = m_valid && !m_ready;
    assign in_beat   = s_valid && s_ready;
    assign drop_beat = m_valid && (m_data.status == qwt_pkg::STAT_FULL
                                   || m_data.status == qwt_pkg::STAT_NONINC);
    assign zero_pos  = (m_data.out_x == 32'sd0) && (m_data.out_y == 32'sd0)
                       && (m_data.out_z == 32'sd0);
    assign sat_beat  = m_valid && (m_data.status == qwt_pkg::STAT_SAT);
    assign at_limit  = m_data.out_x == 32'h7fffffff || m_data.out_x == 32'h80000000
                       || m_data.out_y == 32'h7fffffff || m_data.out_y == 32'h80000000
                       || m_data.out_z == 32'h7fffffff || m_data.out_z == 32'h80000000;

    // A result beat that is not taken stays put.
    `QWT_ASSERT_NEXT(a_hold, aclk, aresetn, out_stall, m_valid && $stable(m_data), "beat moved")

    // One beat at a time: after an input beat is taken the core is busy.
    `QWT_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, in_beat, !s_ready, "input taken twice")

    // A dropped waypoint reports zero positions.
    `QWT_ASSERT_NOW(a_drop_zero, aclk, aresetn, drop_beat, zero_pos, "dropped point not zero")

    // A saturated result has at least one axis at a range limit.
    `QWT_ASSERT_NOW(a_sat_limit, aclk, aresetn, sat_beat, at_limit, "saturated, no axis at limit")

endmodule

bind quintic_waypoint_trajectory_3axis_core qwt_checker u_qwt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
